[sv/held_key_set_defines.svh]
// assertion macros for the held key set
`ifndef HELD_KEY_SET_DEFINES_SVH
`define HELD_KEY_SET_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define HKS_ASSERT_IMP(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (conseq)) \
        else $error("held_key_set assertion failed");
// next-cycle implication
`define HKS_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error("held_key_set assertion failed");
`else
`define HKS_ASSERT_IMP(label, cond, conseq)
`define HKS_ASSERT_NEXT(label, cond, conseq)
`endif

`endif

[sv/hks_pkg.sv]
`timescale 1ns / 1ps

package hks_pkg;

    localparam int CMD_W         = 2;
    localparam int KEY_W         = 9;
    localparam int CNT_OUT_W     = 5;
    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_BITS_DEF  = 9;

    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
    } t_hks_in;

    typedef struct packed {
        logic                 was_present;
        logic                 changed;
        logic                 dropped_full;
        logic [CNT_OUT_W-1:0] entry_count;
    } t_hks_out;

    // write enables broadcast to every cell
    typedef struct packed {
        logic add_en;
        logic rem_en;
    } t_hks_ctl;

endpackage

[sv/held_key_set.sv]
// held_key_set: ordered set of held key codes in a row of compare/shift cells
// result: registered, valid in the cycle after the request is accepted
// throughput: one request per cycle unless stalled; every cell compares and
//   shifts on accept, so the compare ripple along the cell row sets the clock
// reset: clears the held count and the result valid; cell entries are not
//   reset and are only read below the count
`timescale 1ns / 1ps
`include "held_key_set_defines.svh"

module held_key_set
    import hks_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_hks_in  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_hks_out o_out_res
);

    // only the low bits of the key that fit both the field and the cells matter
    localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    t_hks_out         r_res;
    t_hks_out         n_res;

    logic             w_in_acc;
    logic [KW-1:0]    w_key;
    logic             w_present;
    logic             w_full;
    t_hks_ctl         w_ctl;
    logic             w_dropped;

    // take chain: bit i is high when a match sits below cell i
    logic [CAPACITY:0] w_take;
    logic [KW-1:0]     w_entry [CAPACITY];

    // input side only waits while a finished result is held by the consumer
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_key      = i_in_req.key[KW-1:0];
    assign w_take[0]  = 1'b0;

    // keys are unique below the count, so the top of the chain is membership
    assign w_present  = w_take[CAPACITY];
    assign w_full     = (r_count == CNT_W'(CAPACITY));

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KW-1:0] w_next;
        // top cell pulls its own value; it falls above the count anyway
        if (g == CAPACITY - 1) begin : g_top
            assign w_next = w_entry[g];
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end

        hks_cell #(
            .KW (KW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_key        (w_key),
            .i_ctl        (w_ctl),
            .i_live       (CNT_W'(g) < r_count),
            .i_tail       (CNT_W'(g) == r_count),
            .i_take       (w_take[g]),
            .i_next_entry (w_next),
            .o_take       (w_take[g+1]),
            .o_entry      (w_entry[g])
        );
    end

    // command decode: add appends when absent with room, remove when present
    always_comb begin
        w_ctl     = '0;
        w_dropped = 1'b0;
        n_count   = r_count;
        case (i_in_req.cmd)
            CMD_ADD: begin
                if (!w_present) begin
                    if (w_full) begin
                        w_dropped = 1'b1;
                    end else begin
                        w_ctl.add_en = w_in_acc;
                        n_count      = r_count + CNT_W'(1);
                    end
                end
            end
            CMD_REMOVE: begin
                if (w_present) begin
                    w_ctl.rem_en = w_in_acc;
                    n_count      = r_count - CNT_W'(1);
                end
            end
            default: begin
                // query and the unused code leave the table alone
            end
        endcase
    end

    always_comb begin
        n_res.was_present  = w_present;
        n_res.changed      = (n_count != r_count);
        n_res.dropped_full = w_dropped;
        n_res.entry_count  = CNT_OUT_W'(n_count);
    end

    // result register holds until the consumer takes it
    assign n_out_valid = w_in_acc || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_in_acc) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_res;

    // count never runs past the cell row
    `HKS_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY))
    // every accepted request leaves a result behind
    `HKS_ASSERT_NEXT(a_result_follows, w_in_acc, r_out_valid)
    // count only moves on an accepted request
    `HKS_ASSERT_NEXT(a_count_hold, !w_in_acc, $stable(r_count))
    // a refused add can only come from a full row, which stays full
    `HKS_ASSERT_IMP(a_drop_full, r_out_valid && r_res.dropped_full,
                    r_count == CNT_W'(CAPACITY))

endmodule

[sv/hks_cell.sv]
`timescale 1ns / 1ps

module hks_cell
    import hks_pkg::*;
#(
    parameter int KW = KEY_BITS_DEF
) (
    input  logic          i_clk,
    input  logic [KW-1:0] i_key,
    input  t_hks_ctl      i_ctl,
    input  logic          i_live,
    input  logic          i_tail,
    input  logic          i_take,
    input  logic [KW-1:0] i_next_entry,
    output logic          o_take,
    output logic [KW-1:0] o_entry
);

    logic [KW-1:0] r_entry;
    logic          w_match;

    assign w_match = i_live && (r_entry == i_key);
    // a match here or below means this slot pulls from its upper neighbor
    assign o_take  = i_take || w_match;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rem_en && o_take) begin
            r_entry <= i_next_entry;
        end else if (i_ctl.add_en && i_tail) begin
            r_entry <= i_key;
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import hks_pkg::*;

    // command code the block does not define; it must act as a query
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // the slowest run sees ~2000 requests, each behind the longest idle_length
    // sender gap and receiver stall, plus one long hold-off; allow well over that
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_CAP    = 50;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_hks_in  i_in_req = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_hks_out o_out_res;

    held_key_set dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_res  (o_out_res)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the held key table, in insertion order
    logic [KEY_W-1:0] shadow_keys [CAPACITY_DEF];
    int               shadow_count = 0;

    // results still owed by the block, oldest first
    t_hks_out owed_results [$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // idle behavior, changed per test
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int out_hold_cycles = 0;   // long receiver hold-off, set by a test
    int out_stall_left = 0;

    // keys that the random traffic draws from, so hits are common
    logic [KEY_W-1:0] key_pool [$];

    // apply one request to the shadow table and return what the block must answer
    function automatic t_hks_out apply_key_event(input t_hks_in req);
        t_hks_out res;
        int       slot;
        res  = '0;
        slot = -1;
        // first match below the count only
        for (int i = 0; i < shadow_count; i++) begin
            if (slot < 0 && shadow_keys[i] == req.key) begin
                slot = i;
            end
        end
        res.was_present = (slot >= 0);
        case (req.cmd)
            CMD_ADD: begin
                if (slot < 0) begin
                    if (shadow_count < CAPACITY_DEF) begin
                        shadow_keys[shadow_count] = req.key;
                        shadow_count++;
                        res.changed = 1'b1;
                    end else begin
                        // absent key, no room
                        res.dropped_full = 1'b1;
                    end
                end
            end
            CMD_REMOVE: begin
                if (slot >= 0) begin
                    // close the gap: later entries move down one place
                    for (int j = slot + 1; j < shadow_count; j++) begin
                        shadow_keys[j-1] = shadow_keys[j];
                    end
                    shadow_count--;
                    res.changed = 1'b1;
                end
            end
            default: begin
                // query and the unused code leave the table alone
            end
        endcase
        res.entry_count = CNT_OUT_W'(shadow_count);
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what,
                     exp_val, got_val);
        end
        mismatch_count++;
    endtask

    // offer one request and hold it until the block takes it
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
        t_hks_in req;
        int      gap;
        req.cmd = cmd;
        req.key = key;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = idle_length();
            i_in_valid <= 1'b0;
            for (int i = 0; i < gap; i++) begin
                // junk on the bus while nothing is offered
                i_in_req <= t_hks_in'($urandom);
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        // accepted at the first edge that sees stall low
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        owed_results.push_back(apply_key_event(req));
    endtask

    // receiver: random stalls, plus the long hold-off when a test asks for it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (out_hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            out_hold_cycles--;
        end else if (out_stall_left > 0) begin
            i_out_stall <= 1'b1;
            out_stall_left--;
        end else if ($urandom_range(0, 99) < recv_stall_pct) begin
            i_out_stall    <= 1'b1;
            out_stall_left = idle_length() - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result checker: every accepted result against the oldest owed one
    always @(posedge i_clk) begin
        t_hks_out exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected result, count field", -1,
                                int'(o_out_res.entry_count));
            end else begin
                exp_res = owed_results.pop_front();
                if (o_out_res.was_present !== exp_res.was_present) begin
                    report_mismatch("was_present", exp_res.was_present,
                                    o_out_res.was_present);
                end
                if (o_out_res.changed !== exp_res.changed) begin
                    report_mismatch("changed", exp_res.changed, o_out_res.changed);
                end
                if (o_out_res.dropped_full !== exp_res.dropped_full) begin
                    report_mismatch("dropped_full", exp_res.dropped_full,
                                    o_out_res.dropped_full);
                end
                if (o_out_res.entry_count !== exp_res.entry_count) begin
                    report_mismatch("entry_count", exp_res.entry_count,
                                    o_out_res.entry_count);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // empty table: misses, a single add, a repeat add, the unused code, a remove
    task automatic test_empty_table();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(CMD_QUERY, 9'h1FF);
        send_request(CMD_REMOVE, 9'h000);     // remove of an absent key
        send_request(CMD_ADD, 9'h000);
        send_request(CMD_ADD, 9'h000);        // add of a present key
        send_request(CMD_UNUSED, 9'h000);     // unused code acts as a query
        send_request(CMD_REMOVE, 9'h000);
    endtask

    // fill to capacity, overflow, repeat add if full, last-slot query, mid remove
    task automatic test_fill_and_overflow();
        logic [KEY_W-1:0] fill_keys [CAPACITY_DEF];
        fill_keys = '{9'h1FF, 9'h100, 9'h0AA, 9'h155, 9'h001, 9'h002, 9'h004, 9'h008,
                      9'h010, 9'h020, 9'h040, 9'h080, 9'h0FF, 9'h1FE, 9'h123, 9'h0DE};
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        foreach (fill_keys[i]) begin
            send_request(CMD_ADD, fill_keys[i]);
        end
        send_request(CMD_ADD, 9'h0F0);        // table full, absent key is dropped
        send_request(CMD_ADD, 9'h155);        // full but present: no drop
        send_request(CMD_QUERY, 9'h0DE);      // last slot
        send_request(CMD_REMOVE, fill_keys[7]);
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_receiver_hold_off();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        out_hold_cycles = 120;
        for (int i = 0; i < 24; i++) begin
            send_request((i % 3 == 2) ? CMD_REMOVE : CMD_ADD,
                         KEY_W'($urandom_range(0, 15)));
        end
    endtask

    // random add, remove and query traffic over a pool of keys
    task automatic test_random_traffic(input int n_items, input int send_pct,
                                       input int recv_pct, input int pool_size);
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        int               r;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        key_pool.delete();
        for (int i = 0; i < pool_size; i++) begin
            key_pool.push_back(KEY_W'($urandom_range(0, (1 << KEY_W) - 1)));
        end
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                cmd = CMD_ADD;
            end else if (r < 75) begin
                cmd = CMD_REMOVE;
            end else if (r < 95) begin
                cmd = CMD_QUERY;
            end else begin
                cmd = CMD_UNUSED;
            end
            // mostly pool keys so that hits and full tables are common
            if ($urandom_range(0, 9) != 0) begin
                key = key_pool[$urandom_range(0, pool_size - 1)];
            end else begin
                key = KEY_W'($urandom);
            end
            send_request(cmd, key);
        end
    endtask

    initial begin
        // reset once, held before the first test
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_fill_and_overflow();
        test_receiver_hold_off();
        test_random_traffic(300, 0, 0, 20);      // back to back, no idling
        test_random_traffic(700, 25, 25, 24);
        test_random_traffic(500, 60, 60, 12);    // heavy idling, small pool
        test_random_traffic(450, 15, 40, 40);    // big pool keeps the table full

        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        // catch any stray result after the last one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/hks_pkg.sv
sv/hks_cell.sv
sv/held_key_set.sv
tb/tb_top.sv
